// ----- hdl/tbsm_pkg.sv -----
// ---------------------------------------------------------------------------
// tbsm_pkg
// Shared types and constants for the triple buffer swap manager: event
// codes, buffer count, stage values and the input and result words.
// ---------------------------------------------------------------------------
package tbsm_pkg;

  // Number of frame buffers and the widths that follow from it.
  localparam int BUF_COUNT = 3;
  localparam int BUF_IDX_W = 2;
  localparam int CNT_W     = 2;
  localparam int STAGE_W   = 8;
  localparam int SKIP_W    = 8;
  localparam int BLANK_W   = 9;

  // Stage value of a buffer that is held by the display path at reset.
  localparam logic [STAGE_W-1:0] STAGE_HELD = 8'hFE;

  // Index of the buffer that starts out free.
  localparam logic [BUF_IDX_W-1:0] RESET_FREE_BUF = 2'd1;

  // Index of the buffer that starts out queued.
  localparam logic [BUF_IDX_W-1:0] RESET_QUEUED_BUF = 2'd0;

  // Event codes.
  typedef enum logic [1:0] {
    OP_VBLANK  = 2'd0,
    OP_DONE    = 2'd1,
    OP_REQUEST = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // One input word.
  typedef struct packed {
    op_t                  op;
    logic [BUF_IDX_W-1:0] done_index;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic                 granted;
    logic [BUF_IDX_W-1:0] grant_index;
    logic                 flipped;
    logic [BUF_IDX_W-1:0] shown_index;
    logic [CNT_W-1:0]     free_buffers;
    logic                 frames_blocked;
    logic                 drained;
    logic                 no_free_error;
  } out_item_t;

  // Control from the pipeline shell to the state core.
  typedef struct packed {
    logic              fire;
    logic              cfg_wr;
    logic [SKIP_W-1:0] cfg_data;
  } core_ctrl_t;

endpackage

// ----- hdl/tbsm_core.sv -----
// ---------------------------------------------------------------------------
// tbsm_core
// Buffer bookkeeping: per-buffer stages, the ready queue, the displayed
// index, the free count, the block flag and the vblank skip counter. One
// event is applied per cycle when the shell fires.
// ---------------------------------------------------------------------------
module tbsm_core
  import tbsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  core_ctrl_t ctrl,
  input  in_item_t   item,
  output out_item_t  result
);

  logic [STAGE_W-1:0]   stage_r   [BUF_COUNT];
  logic [STAGE_W-1:0]   stage_nxt [BUF_COUNT];
  logic [BUF_IDX_W-1:0] queue_r   [BUF_COUNT];
  logic [BUF_IDX_W-1:0] queue_nxt [BUF_COUNT];
  logic [CNT_W-1:0]     ready_count_r, ready_count_nxt;
  logic [BUF_IDX_W-1:0] display_r, display_nxt;
  logic [CNT_W-1:0]     free_total_r, free_total_nxt;
  logic                 block_r, block_nxt;
  logic [BLANK_W-1:0]   blank_r, blank_nxt;
  logic [SKIP_W-1:0]    frame_skip_r;

  logic [BLANK_W-1:0]   blank_inc;
  logic [BUF_IDX_W-1:0] head;
  logic                 found;
  logic [BUF_IDX_W-1:0] found_idx;

  // Lowest free buffer, searched over the stages.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = BUF_COUNT - 1; k >= 0; k--) begin
      if (stage_r[k] == '0) begin
        found     = 1'b1;
        found_idx = BUF_IDX_W'(k);
      end
    end
  end

  // Next state and result for the event at the input register.
  always_comb begin
    stage_nxt       = stage_r;
    queue_nxt       = queue_r;
    ready_count_nxt = ready_count_r;
    display_nxt     = display_r;
    free_total_nxt  = free_total_r;
    block_nxt       = block_r;
    blank_nxt       = blank_r;
    blank_inc       = blank_r + 1'b1;
    head            = queue_r[0];
    result          = '0;

    case (item.op)
      OP_VBLANK: begin
        if (blank_inc <= {1'b0, frame_skip_r}) begin
          blank_nxt = blank_inc;
        end else begin
          blank_nxt = '0;
          if (ready_count_r != '0) begin
            // Pop the head and shift the rest down.
            for (int k = 1; k < BUF_COUNT; k++) begin
              if (CNT_W'(k) < ready_count_r) begin
                queue_nxt[k-1] = queue_r[k];
              end
            end
            ready_count_nxt = ready_count_r - 1'b1;
            if (head < BUF_IDX_W'(BUF_COUNT)) begin
              // The old display buffer is freed after the new one advances.
              for (int k = 0; k < BUF_COUNT; k++) begin
                if (BUF_IDX_W'(k) == head) begin
                  stage_nxt[k] = stage_r[k] + 1'b1;
                end
              end
              for (int k = 0; k < BUF_COUNT; k++) begin
                if (BUF_IDX_W'(k) == display_r) begin
                  stage_nxt[k] = '0;
                end
              end
              if (free_total_r < CNT_W'(BUF_COUNT)) begin
                free_total_nxt = free_total_r + 1'b1;
              end
              display_nxt    = head;
              result.flipped = 1'b1;
            end
          end
        end
      end
      OP_DONE: begin
        if (item.done_index < BUF_IDX_W'(BUF_COUNT)) begin
          for (int k = 0; k < BUF_COUNT; k++) begin
            if (BUF_IDX_W'(k) == item.done_index) begin
              stage_nxt[k] = stage_r[k] + 1'b1;
            end
          end
          // Queue the buffer unless the queue is full.
          if (ready_count_r < CNT_W'(BUF_COUNT)) begin
            for (int k = 0; k < BUF_COUNT; k++) begin
              if (CNT_W'(k) == ready_count_r) begin
                queue_nxt[k] = item.done_index;
              end
            end
            ready_count_nxt = ready_count_r + 1'b1;
          end
          block_nxt = 1'b0;
        end
      end
      OP_REQUEST: begin
        if (free_total_r != '0 && !block_r) begin
          if (found) begin
            result.granted     = 1'b1;
            result.grant_index = found_idx;
            free_total_nxt     = free_total_r - 1'b1;
            block_nxt          = 1'b1;
          end else begin
            result.no_free_error = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        free_total_nxt = CNT_W'(1);
        block_nxt      = 1'b0;
      end
      default: begin
        block_nxt = block_r;
      end
    endcase

    result.shown_index    = display_nxt;
    result.free_buffers   = free_total_nxt;
    result.frames_blocked = block_nxt;
    result.drained        = (free_total_nxt == CNT_W'(BUF_COUNT - 1));
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BUF_COUNT; k++) begin
        stage_r[k] <= (k == int'(RESET_FREE_BUF)) ? '0 : STAGE_HELD;
        queue_r[k] <= (k == 0) ? RESET_QUEUED_BUF : '0;
      end
      ready_count_r             <= CNT_W'(1);
      display_r                 <= BUF_IDX_W'(BUF_COUNT - 1);
      free_total_r              <= CNT_W'(1);
      block_r                   <= 1'b0;
      blank_r                   <= '0;
    end else if (ctrl.fire) begin
      stage_r       <= stage_nxt;
      queue_r       <= queue_nxt;
      ready_count_r <= ready_count_nxt;
      display_r     <= display_nxt;
      free_total_r  <= free_total_nxt;
      block_r       <= block_nxt;
      blank_r       <= blank_nxt;
    end
  end

  // Frame skip register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_skip_r <= '0;
    end else if (ctrl.cfg_wr) begin
      frame_skip_r <= ctrl.cfg_data;
    end
  end

  // A grant always leaves frames blocked.
  a_grant_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fire && result.granted |=> block_r)
    else $error("grant did not set the block flag");

  // A flip always consumes one queued buffer.
  a_flip_pops: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fire && result.flipped |=> ready_count_r == $past(ready_count_r) - 1'b1)
    else $error("flip did not pop the ready queue");

  // A request never grants and reports an error together.
  a_grant_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fire |-> !(result.granted && result.no_free_error))
    else $error("grant and no-free error at once");

  // Bookkeeping stays within the buffer count.
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ready_count_r <= CNT_W'(BUF_COUNT) && free_total_r <= CNT_W'(BUF_COUNT)
    && display_r < BUF_IDX_W'(BUF_COUNT))
    else $error("buffer bookkeeping out of range");

endmodule

// ----- hdl/triple_buffer_swap_manager_unit.sv -----
// An event is held in the input register; its result word is then registered.
// One event per cycle when out_stall is low; the state core updates in one pass.
// The input register refills in the cycle its event moves to the result register.
// Reset (synchronous, active low) empties both registers and loads the buffer
// state: buffer 1 free, buffer 0 queued, the last buffer shown, frame skip zero.
// ---------------------------------------------------------------------------
// triple_buffer_swap_manager_unit
// Top level: input register, state core and result register around a
// valid/stall handshake on each side, plus the frame skip write port.
// ---------------------------------------------------------------------------
module triple_buffer_swap_manager_unit
  import tbsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SKIP_W-1:0] cfg_data
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  result;
  core_ctrl_t ctrl;
  logic       fire;

  // The held event moves on when the result register is empty or draining.
  assign fire      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign cfg_ready = 1'b1;

  assign ctrl.fire     = fire;
  assign ctrl.cfg_wr   = cfg_valid && cfg_ready;
  assign ctrl.cfg_data = cfg_data;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  tbsm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .item   (in_item_r),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- bench/tb_triple_buffer_swap_manager_unit.sv -----
// ---------------------------------------------------------------------------
// tb_triple_buffer_swap_manager_unit
// Drives display and render events into the swap manager under random idle
// and stall patterns. A tracker class predicts each result word from its own
// copy of the buffer state and compares it field by field. The run covers
// several frame skip settings, from zero up to the largest.
// ---------------------------------------------------------------------------
module tb_triple_buffer_swap_manager_unit
  import tbsm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Follows the buffer hand-off and holds the result words still due.
  class swap_chain_tracker;
    logic [STAGE_W-1:0]   stage [BUF_COUNT];
    logic [BUF_IDX_W-1:0] ready_fifo [$];
    logic [BUF_IDX_W-1:0] shown;
    logic [CNT_W-1:0]     free_cnt;
    logic                 blocked;
    logic [BLANK_W-1:0]   blanks;
    logic [SKIP_W-1:0]    skip;
    logic [BUF_IDX_W-1:0] last_grant;
    out_item_t            expected_reports [$];
    int                   mismatches;

    function new();
      for (int k = 0; k < BUF_COUNT; k++) stage[k] = STAGE_HELD;
      stage[RESET_FREE_BUF] = '0;
      ready_fifo.push_back(RESET_QUEUED_BUF);
      shown = BUF_IDX_W'(BUF_COUNT - 1);
      free_cnt = CNT_W'(1);
      blocked = 1'b0;
      blanks = '0;
      skip = '0;
      last_grant = RESET_FREE_BUF;
      mismatches = 0;
    endfunction

    function void set_skip(logic [SKIP_W-1:0] value);
      skip = value;
    endfunction

    // Apply one accepted event and queue the result word it produces.
    function void note_event(in_item_t w);
      out_item_t            rep;
      logic [BUF_IDX_W-1:0] nxt;
      bit                   found;
      rep = '0;
      found = 1'b0;
      case (w.op)
        OP_VBLANK: begin
          blanks = blanks + 1'b1;
          if (blanks > {1'b0, skip}) begin
            // Flip attempt: show the oldest finished buffer, free the old one.
            if (ready_fifo.size() > 0) begin
              nxt = ready_fifo.pop_front();
              stage[nxt] = stage[nxt] + 1'b1;
              stage[shown] = '0;
              if (free_cnt < BUF_COUNT) free_cnt = free_cnt + 1'b1;
              shown = nxt;
              rep.flipped = 1'b1;
            end
            blanks = '0;
          end
        end
        OP_DONE: begin
          // Out-of-range indexes are ignored; a full queue drops the index.
          if (w.done_index < BUF_COUNT) begin
            stage[w.done_index] = stage[w.done_index] + 1'b1;
            if (ready_fifo.size() < BUF_COUNT) ready_fifo.push_back(w.done_index);
            blocked = 1'b0;
          end
        end
        OP_REQUEST: begin
          if (free_cnt != 0 && !blocked) begin
            for (int k = 0; k < BUF_COUNT; k++) begin
              if (!found && stage[k] == '0) begin
                found = 1'b1;
                rep.granted = 1'b1;
                rep.grant_index = BUF_IDX_W'(k);
              end
            end
            if (found) begin
              free_cnt = free_cnt - 1'b1;
              blocked = 1'b1;
              last_grant = rep.grant_index;
            end
            rep.no_free_error = !found;
          end
        end
        OP_RELEASE: begin
          free_cnt = CNT_W'(1);
          blocked = 1'b0;
        end
      endcase
      rep.shown_index = shown;
      rep.free_buffers = free_cnt;
      rep.frames_blocked = blocked;
      rep.drained = (free_cnt == BUF_COUNT - 1);
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare an accepted result word with the oldest prediction.
    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $error("result word arrived with no event outstanding");
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("granted", 4'(want.granted), 4'(got.granted));
      compare_field("grant_index", 4'(want.grant_index), 4'(got.grant_index));
      compare_field("flipped", 4'(want.flipped), 4'(got.flipped));
      compare_field("shown_index", 4'(want.shown_index), 4'(got.shown_index));
      compare_field("free_buffers", 4'(want.free_buffers), 4'(got.free_buffers));
      compare_field("frames_blocked", 4'(want.frames_blocked), 4'(got.frames_blocked));
      compare_field("drained", 4'(want.drained), 4'(got.drained));
      compare_field("no_free_error", 4'(want.no_free_error), 4'(got.no_free_error));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SKIP_W-1:0] cfg_data = '0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  swap_chain_tracker tracker = new();

  triple_buffer_swap_manager_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check each accepted word, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_report(out_item);
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Offer one event word, idling first at random, and hold it until taken.
  task automatic send_event(op_t op, logic [BUF_IDX_W-1:0] idx);
    in_item_t w;
    w.op = op;
    w.done_index = idx;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_event(w);
  endtask

  // Let every outstanding result drain, then a short settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_skip(logic [SKIP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_skip(value);
  endtask

  // Mostly request / render done / vblank rounds, with random noise mixed in.
  task automatic run_traffic(int words);
    int sent;
    int burst;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(99) < 75) begin
        send_event(OP_REQUEST, BUF_IDX_W'($urandom_range(3)));
        send_event(OP_DONE, tracker.last_grant);
        burst = $urandom_range(int'(tracker.skip) + 2, 1);
        for (int k = 0; k < burst; k++) send_event(OP_VBLANK, BUF_IDX_W'($urandom_range(3)));
        sent += 2 + burst;
      end else begin
        send_event(op_t'($urandom_range(3)), BUF_IDX_W'($urandom_range(3)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flips, empty queue, blocking, ignored index, error, full queue.
    write_skip(8'd0);
    send_event(OP_VBLANK, 2'd0);
    send_event(OP_VBLANK, 2'd3);
    send_event(OP_REQUEST, 2'd0);
    send_event(OP_REQUEST, 2'd0);
    send_event(OP_DONE, 2'd3);
    send_event(OP_DONE, 2'd1);
    send_event(OP_REQUEST, 2'd0);
    send_event(OP_DONE, 2'd2);
    send_event(OP_REQUEST, 2'd0);
    send_event(OP_RELEASE, 2'd0);
    send_event(OP_REQUEST, 2'd0);
    send_event(OP_DONE, 2'd0);
    send_event(OP_DONE, 2'd1);
    send_event(OP_REQUEST, 2'd3);
    send_event(OP_VBLANK, 2'd0);
    send_event(OP_VBLANK, 2'd0);
    send_event(OP_VBLANK, 2'd0);
    send_event(OP_VBLANK, 2'd0);
    send_event(OP_RELEASE, 2'd3);
    send_event(OP_REQUEST, 2'd0);
    wait_drained();

    // Sender idles a third of the time, receiver stalls most of it.
    snd_idle_pct = 32;
    rcv_idle_pct = 88;
    write_skip(8'd2);
    run_traffic(400);
    wait_drained();

    // Largest skip; the roles of sender and receiver swap.
    snd_idle_pct = 88;
    rcv_idle_pct = 32;
    write_skip(8'd255);
    run_traffic(400);
    wait_drained();

    // Full rate on both sides.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_skip(8'd0);
    run_traffic(250);
    wait_drained();
    write_skip(SKIP_W'($urandom_range(7, 1)));
    run_traffic(250);
    wait_drained();

    if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tbsm_pkg.sv
hdl/tbsm_core.sv
hdl/triple_buffer_swap_manager_unit.sv
bench/tb_triple_buffer_swap_manager_unit.sv
